### rtl/free_channel_picker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the free channel picker
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FREE_CHANNEL_PICKER_TOP_ASSERT_SVH
`define FREE_CHANNEL_PICKER_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define FCP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// consequent in the cycle after the antecedent
`define FCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

### rtl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types and constants of the free channel picker.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

    localparam int FREQ_W        = 31;
    localparam int STEP_W        = 16;
    localparam int CAND_W        = 32;
    localparam int MAX_FREQS_DEF = 64;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd2500;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [CAND_W-1:0] noise_freq;
        logic              overflow;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_round;
        logic mean_take;
        logic round_take;
        logic scan_rd;
        logic scan_cmp;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic step_zero;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/free_channel_picker_top.sv
// ----------------------------------------------------------------------------
// free_channel_picker_top
// Picks a free grid frequency clear of a loaded list of occupied ones.
// ----------------------------------------------------------------------------
// Loading takes one item per cycle while item_stall is low. After the item
// marked last, the mean goes through a one-bit-per-cycle divider over the sum
// width (31 + log2(MAX_FREQS) bits, 37 at the default), then the rounding to
// the channel grid reuses the same divider (skipped when the step is zero).
// The clearance scan reads the frequency store one entry at a time, a read
// state then a compare state, and restarts at entry zero after every move;
// the result is then emitted, held for as long as an earlier result still
// waits to leave. Input is stalled from the last item until the result is
// in the output register; the next list may load while that result waits.
// The step register is written through cfg_data, which is always ready.
`default_nettype none

module free_channel_picker_top #(
    parameter int MAX_FREQS = fcp_pkg::MAX_FREQS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire fcp_pkg::item_t             item,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output fcp_pkg::result_t                result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [fcp_pkg::STEP_W-1:0] cfg_data
);

    fcp_pkg::cmd_t cmd;
    fcp_pkg::sts_t sts;

    fcp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    fcp_datapath #(
        .MAX_FREQS (MAX_FREQS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

### rtl/fcp_div.sv
// ----------------------------------------------------------------------------
// fcp_div
// Restoring divider, one quotient bit per cycle, done pulses once at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_div #(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR_W  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift the dividend out at the top, quotient bits in at the bottom
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor})
                            : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/fcp_datapath.sv
// ----------------------------------------------------------------------------
// fcp_datapath
// Frequency store, running sum, shared divider, candidate scan and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_datapath #(
    parameter int MAX_FREQS = fcp_pkg::MAX_FREQS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fcp_pkg::item_t              item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [fcp_pkg::STEP_W-1:0]  cfg_data,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output fcp_pkg::result_t                 result,
    input  wire fcp_pkg::cmd_t               cmd,
    output fcp_pkg::sts_t                    sts
);

    localparam int FREQ_W = fcp_pkg::FREQ_W;
    localparam int STEP_W = fcp_pkg::STEP_W;
    localparam int CAND_W = fcp_pkg::CAND_W;
    localparam int CNT_W  = $clog2(MAX_FREQS + 1);
    localparam int IDX_W  = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
    localparam int SUM_W  = FREQ_W + IDX_W;

    logic [FREQ_W-1:0] mem [MAX_FREQS];

    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              dropped_reg;
    logic [FREQ_W-1:0] mean_reg;
    logic [CAND_W-1:0] cand_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [FREQ_W-1:0] rd_reg;
    logic              result_valid_reg;
    fcp_pkg::result_t  result_reg;

    logic              full;
    logic              store_en;
    logic [SUM_W-1:0]  div_dividend;
    logic [STEP_W-1:0] div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;
    logic [STEP_W-1:0] div_rem;
    logic [CAND_W:0]   cand_ext;
    logic [CAND_W:0]   f_ext;
    logic [CAND_W:0]   step_ext;
    logic              hit;
    logic              out_free;

    assign full     = count_reg == CNT_W'(MAX_FREQS);
    assign store_en = cmd.load && !full;
    assign cfg_ready = 1'b1;

    assign div_dividend = cmd.div_round ? SUM_W'(mean_reg) : sum_reg;
    assign div_divisor  = cmd.div_round ? step_reg : STEP_W'(count_reg);

    fcp_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (STEP_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // too close when |cand - f| < step, written as two parallel compares
    assign cand_ext = {1'b0, cand_reg};
    assign f_ext    = (CAND_W + 1)'(rd_reg);
    assign step_ext = (CAND_W + 1)'(step_reg);
    assign hit      = (cand_ext + step_ext > f_ext) && (f_ext + step_ext > cand_ext);

    assign out_free = !result_valid_reg || !result_stall;

    assign sts.div_done  = div_done;
    assign sts.step_zero = step_reg == '0;
    assign sts.scan_hit  = hit;
    assign sts.scan_last = CNT_W'(idx_reg) + CNT_W'(1) == count_reg;
    assign sts.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= item.freq;
        end
        if (cmd.scan_rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_take)
        begin
            mean_reg <= div_quot[FREQ_W-1:0];
        end
        if (cmd.emit)
        begin
            result_reg.noise_freq <= cand_reg;
            result_reg.overflow   <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= fcp_pkg::STEP_RESET;
            count_reg        <= '0;
            sum_reg          <= '0;
            dropped_reg      <= 1'b0;
            cand_reg         <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end

            if (store_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_reg + SUM_W'(item.freq);
            end
            else if (cmd.load)
            begin
                dropped_reg <= 1'b1;
            end

            priority if (cmd.mean_take)
            begin
                cand_reg <= CAND_W'(div_quot[FREQ_W-1:0]);
            end
            else if (cmd.round_take)
            begin
                cand_reg <= CAND_W'(mean_reg) - CAND_W'(div_rem);
            end
            else if (cmd.scan_cmp && hit)
            begin
                cand_reg <= cand_reg + CAND_W'(step_reg);
            end

            // restart the scan at entry zero after every move
            if (cmd.scan_cmp)
            begin
                idx_reg <= hit ? '0 : idx_reg + IDX_W'(1);
            end

            if (cmd.emit)
            begin
                count_reg   <= '0;
                sum_reg     <= '0;
                dropped_reg <= 1'b0;
                idx_reg     <= '0;
            end

            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### rtl/fcp_ctrl.sv
// ----------------------------------------------------------------------------
// fcp_ctrl
// Sequencer: load, mean divide, grid rounding unless the step is zero, clearance scan, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          item_last,
    output logic               item_stall,
    input  wire fcp_pkg::sts_t sts,
    output fcp_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_MEAN_GO   = 3'd1;
    localparam logic [2:0] S_MEAN_WAIT = 3'd2;
    localparam logic [2:0] S_RND_GO    = 3'd3;
    localparam logic [2:0] S_RND_WAIT  = 3'd4;
    localparam logic [2:0] S_SCAN_RD   = 3'd5;
    localparam logic [2:0] S_SCAN_CMP  = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    logic [2:0] state_reg, state_next;

    assign item_stall = state_reg != S_LOAD;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        state_next = S_MEAN_GO;
                    end
                end
            end
            S_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_take = 1'b1;
                    // a zero step leaves the mean unrounded
                    state_next = sts.step_zero ? S_SCAN_RD : S_RND_GO;
                end
            end
            S_RND_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_round = 1'b1;
                state_next    = S_RND_WAIT;
            end
            S_RND_WAIT:
            begin
                cmd.div_round = 1'b1;
                if (sts.div_done)
                begin
                    cmd.round_take = 1'b1;
                    state_next     = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (!sts.scan_hit && sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_EMIT:
            begin
                // hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fcp_checker.sv
// ----------------------------------------------------------------------------
// fcp_checker
// Port-level checks of the free channel picker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_channel_picker_top_assert.svh"

module fcp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire fcp_pkg::item_t   item,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire fcp_pkg::result_t result
);

    // a stalled result holds
    `FCP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // the last item of a list starts the computation and blocks input
    `FCP_ASSERT_NEXT(a_last_stalls, item_valid && !item_stall && item.last, item_stall)

    // a fresh result only follows a cycle of computation
    `FCP_ASSERT_SAME(a_result_after_work, $rose(result_valid), $past(item_stall))

    // input reopens only once the result has been registered
    `FCP_ASSERT_SAME(a_reopen_with_result, $fell(item_stall), result_valid)

endmodule

bind free_channel_picker_top fcp_checker u_fcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
